### hdl/tanco_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tanco_pkg
// Shared constants for the three-axis NCO step generator.
// ----------------------------------------------------------------------------
package tanco_pkg;

  // Default widths and axis count
  localparam int PHASE_BITS_DEF = 24;
  localparam int NUM_AXES_DEF   = 3;
  localparam int TICK_BITS_DEF  = 32;

  // Fixed pin field width and joint select width
  localparam int PIN_COUNT = 3;
  localparam int SEL_BITS  = 2;

  // Wide enough to compare a joint number against any axis index up to 15
  localparam int JOINT_CMP_BITS = 4;

endpackage : tanco_pkg
`default_nettype wire

### hdl/three_axis_nco_step_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_nco_step_generator
// Per-axis phase accumulators producing step, direction and enable pins,
// one tick per accepted input word.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid / in_stall | has_move joint_sel move_direction
//           |           |                     | move_rate move_ticks
//   out     | output    | out_valid/out_stall | step_pins dir_pins enable_n_pins
//
// One word per cycle while in_stall is low; the result is held in the output
// register from the cycle after acceptance. Axis state updates at the accepting edge.
// in_stall is raised only while the output register is full and stalled.
// Synchronous reset: phases, rates and counts clear, enables go high.
// ----------------------------------------------------------------------------
module three_axis_nco_step_generator #(
  parameter int PHASE_BITS = tanco_pkg::PHASE_BITS_DEF,
  parameter int NUM_AXES   = tanco_pkg::NUM_AXES_DEF,
  parameter int TICK_BITS  = tanco_pkg::TICK_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             has_move,
  input  wire logic [tanco_pkg::SEL_BITS-1:0]   joint_sel,
  input  wire logic                             move_direction,
  input  wire logic [PHASE_BITS-1:0]            move_rate,
  input  wire logic [TICK_BITS-1:0]             move_ticks,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [tanco_pkg::PIN_COUNT-1:0]       step_pins,
  output logic [tanco_pkg::PIN_COUNT-1:0]       dir_pins,
  output logic [tanco_pkg::PIN_COUNT-1:0]       enable_n_pins
);

  localparam logic [PHASE_BITS-1:0] PHASE_MAX = {PHASE_BITS{1'b1}};
  localparam int CB = tanco_pkg::JOINT_CMP_BITS;

  logic accept;

  // per-axis state
  logic [PHASE_BITS-1:0] phase     [NUM_AXES];
  logic [PHASE_BITS-1:0] rate      [NUM_AXES];
  logic [TICK_BITS-1:0]  remaining [NUM_AXES];
  logic [NUM_AXES-1:0]   direction;
  logic [NUM_AXES-1:0]   enable_n;

  // per-axis next values and this tick's pins
  logic [NUM_AXES-1:0]   pulse;
  logic [NUM_AXES-1:0]   direction_next;
  logic [NUM_AXES-1:0]   enable_n_next;

  logic [tanco_pkg::PIN_COUNT-1:0] step_next;
  logic [tanco_pkg::PIN_COUNT-1:0] dir_next;
  logic [tanco_pkg::PIN_COUNT-1:0] en_next;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    logic                  load;
    logic [PHASE_BITS-1:0] rate_eff;
    logic [TICK_BITS-1:0]  rem_eff;
    logic [TICK_BITS-1:0]  remaining_next;
    logic [PHASE_BITS:0]   sum;
    logic [PHASE_BITS:0]   sum_wrapped;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] rate_next;

    always_comb begin
      load = has_move & ({{(CB - tanco_pkg::SEL_BITS){1'b0}}, joint_sel} == CB'(i + 1));

      rate_eff          = load ? move_rate : rate[i];
      rem_eff           = load ? move_ticks : remaining[i];
      direction_next[i] = load ? move_direction : direction[i];
      enable_n_next[i]  = load ? 1'b0 : enable_n[i];

      sum         = {1'b0, phase[i]} + {1'b0, rate_eff};
      sum_wrapped = sum - {1'b0, PHASE_MAX};
      pulse[i]    = (sum > {1'b0, PHASE_MAX});
      phase_next  = pulse[i] ? sum_wrapped[PHASE_BITS-1:0] : sum[PHASE_BITS-1:0];

      // count down; the tuning word drops once the count reaches zero
      remaining_next = (rem_eff != '0) ? rem_eff - TICK_BITS'(1) : rem_eff;
      rate_next      = (remaining_next == '0) ? '0 : rate_eff;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        phase[i]     <= '0;
        rate[i]      <= '0;
        remaining[i] <= '0;
        direction[i] <= 1'b0;
        enable_n[i]  <= 1'b1;
      end else if (accept) begin
        phase[i]     <= phase_next;
        rate[i]      <= rate_next;
        remaining[i] <= remaining_next;
        direction[i] <= direction_next[i];
        enable_n[i]  <= enable_n_next[i];
      end
    end
  end

  // axes beyond the pin field are dropped; missing axes read as zero
  for (genvar p = 0; p < tanco_pkg::PIN_COUNT; p++) begin : g_pin
    if (p < NUM_AXES) begin : g_used
      assign step_next[p] = pulse[p];
      assign dir_next[p]  = direction_next[p];
      assign en_next[p]   = enable_n_next[p];
    end else begin : g_unused
      assign step_next[p] = 1'b0;
      assign dir_next[p]  = 1'b0;
      assign en_next[p]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_pins     <= step_next;
      dir_pins      <= dir_next;
      enable_n_pins <= en_next;
    end
  end

endmodule : three_axis_nco_step_generator
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis NCO step generator. Ticks are sent
// one word at a time through a directed set (reset state, ignored joints,
// the off-by-one wrap, short moves, field extremes) and then through random
// move sequences under several idling patterns on both channels. A local
// model of the per-joint accumulators predicts the step, direction and
// enable pins of each tick, and every output word is checked against it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PB = tanco_pkg::PHASE_BITS_DEF;
  localparam int NA = tanco_pkg::NUM_AXES_DEF;
  localparam int TB = tanco_pkg::TICK_BITS_DEF;
  localparam int PINS = tanco_pkg::PIN_COUNT;
  localparam logic [PB-1:0] PHASE_TOP = {PB{1'b1}};
  localparam logic [TB-1:0] TICKS_TOP = {TB{1'b1}};
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [PINS-1:0] step;
    logic [PINS-1:0] dir;
    logic [PINS-1:0] en_n;
  } pin_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  logic has_move = 1'b0;
  logic [tanco_pkg::SEL_BITS-1:0] joint_sel = '0;
  logic move_direction = 1'b0;
  logic [PB-1:0] move_rate = '0;
  logic [TB-1:0] move_ticks = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [PINS-1:0] step_pins;
  logic [PINS-1:0] dir_pins;
  logic [PINS-1:0] enable_n_pins;

  // joint state as the block should hold it
  logic [PB-1:0] acc_phase [NA];
  logic [PB-1:0] tuning [NA];
  logic [TB-1:0] ticks_left [NA];
  logic dir_level [NA];
  logic en_n [NA];

  pin_word_t expected_pins [$];
  int fail_count = 0;
  int pins_checked = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  three_axis_nco_step_generator DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .has_move(has_move),
    .joint_sel(joint_sel),
    .move_direction(move_direction),
    .move_rate(move_rate),
    .move_ticks(move_ticks),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step_pins(step_pins),
    .dir_pins(dir_pins),
    .enable_n_pins(enable_n_pins)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // one tick of all joints; pushes the pins it should produce
  task automatic advance_axes(input logic hm, input logic [1:0] js, input logic d,
                              input logic [PB-1:0] r, input logic [TB-1:0] t);
    logic [PB:0] sum;
    pin_word_t w;
    int j;
    w = '0;
    if (hm && js >= 1 && js <= NA) begin
      j = js - 1;
      dir_level[j] = d;
      tuning[j] = r;
      ticks_left[j] = t;
      en_n[j] = 1'b0;
    end
    for (int i = 0; i < NA; i++) begin
      sum = {1'b0, acc_phase[i]} + {1'b0, tuning[i]};
      // wrap takes off 2^N - 1, so a phase of all ones does not step
      if (sum > {1'b0, PHASE_TOP}) begin
        sum = sum - {1'b0, PHASE_TOP};
        if (i < PINS) w.step[i] = 1'b1;
      end
      acc_phase[i] = sum[PB-1:0];
      if (i < PINS) begin
        w.dir[i] = dir_level[i];
        w.en_n[i] = en_n[i];
      end
      if (ticks_left[i] != 0) ticks_left[i] = ticks_left[i] - 1'b1;
      if (ticks_left[i] == 0) tuning[i] = '0;
    end
    expected_pins.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [PINS-1:0] got,
                                 input logic [PINS-1:0] want);
    $display("mismatch on word %0d: %s got %b want %b", pins_checked, what, got, want);
    fail_count++;
  endtask

  // output side: decide at the falling edge, the word moves at the next rise
  always @(negedge clk) begin
    pin_word_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_pins.size() == 0) begin
        $display("unexpected output word %0d", pins_checked);
        fail_count++;
      end else begin
        want = expected_pins.pop_front();
        if (step_pins !== want.step) report_mismatch("step_pins", step_pins, want.step);
        if (dir_pins !== want.dir) report_mismatch("dir_pins", dir_pins, want.dir);
        if (enable_n_pins !== want.en_n)
          report_mismatch("enable_n_pins", enable_n_pins, want.en_n);
      end
      pins_checked++;
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_tick(input logic hm, input logic [1:0] js, input logic d,
                           input logic [PB-1:0] r, input logic [TB-1:0] t);
    bit taken;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    has_move <= hm;
    joint_sel <= js;
    move_direction <= d;
    move_rate <= r;
    move_ticks <= t;
    do begin
      @(negedge clk);
      taken = (in_stall == 1'b0);
      @(posedge clk);
    end while (!taken);
    advance_axes(hm, js, d, r, t);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_after_reset();
    send_tick(1'b0, 2'd0, 1'b0, '0, '0);
    // move flag low: payload must be ignored
    send_tick(1'b0, 2'd3, 1'b1, PHASE_TOP, TICKS_TOP);
  endtask

  task automatic test_no_joint();
    send_tick(1'b1, 2'd0, 1'b1, PHASE_TOP, TICKS_TOP);
    send_tick(1'b1, 2'd0, 1'b0, '0, '0);
  endtask

  task automatic test_wrap_constant();
    send_tick(1'b1, 2'd1, 1'b1, PHASE_TOP, 32'd2);
    send_tick(1'b0, 2'd0, 1'b0, '0, '0);
    send_tick(1'b0, 2'd0, 1'b0, '0, '0);
    send_tick(1'b1, 2'd1, 1'b0, 24'd1, 32'd1);
  endtask

  task automatic test_short_moves();
    send_tick(1'b1, 2'd2, 1'b0, 24'h800000, 32'd0);
    send_tick(1'b0, 2'd2, 1'b0, '0, '0);
    send_tick(1'b1, 2'd3, 1'b1, 24'h800000, 32'd1);
    send_tick(1'b0, 2'd3, 1'b0, '0, '0);
  endtask

  task automatic test_field_extremes();
    send_tick(1'b1, 2'd3, 1'b0, '0, TICKS_TOP);
    send_tick(1'b1, 2'd2, 1'b1, PHASE_TOP, TICKS_TOP);
    send_tick(1'b0, 2'd0, 1'b0, '0, '0);
    send_tick(1'b0, 2'd1, 1'b1, '0, '0);
    // three-tick move at rate zero: the enable goes low but no steps come
    send_tick(1'b1, 2'd2, 1'b0, '0, 32'd3);
    send_tick(1'b0, 2'd0, 1'b0, '0, '0);
  endtask

  task automatic test_random_moves(input int count);
    logic hm;
    logic [1:0] js;
    logic [PB-1:0] r;
    logic [TB-1:0] t;
    for (int n = 0; n < count; n++) begin
      hm = ($urandom_range(0, 99) < 65);
      js = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      case ($urandom_range(0, 7))
        0, 1, 2, 3: r = PB'($urandom);
        4:          r = PB'($urandom_range(1, 4095));
        5:          r = PHASE_TOP;
        6:          r = '0;
        default:    r = PHASE_TOP - PB'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        6:       t = $urandom;
        7:       t = '0;
        8:       t = 32'd1;
        9:       t = TICKS_TOP;
        default: t = TB'($urandom_range(2, 30));
      endcase
      send_tick(hm, js, 1'($urandom_range(0, 1)), r, t);
    end
  endtask

  initial begin
    for (int i = 0; i < NA; i++) begin
      acc_phase[i] = '0;
      tuning[i] = '0;
      ticks_left[i] = '0;
      dir_level[i] = 1'b0;
      en_n[i] = 1'b1;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_idle_after_reset();
    test_no_joint();
    test_wrap_constant();
    test_short_moves();
    test_field_extremes();

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_moves(160);
    send_idle_pct = 80;
    test_random_moves(160);
    send_idle_pct = 0;
    stall_pct = 80;
    test_random_moves(80);
    drain_results();
    test_random_moves(80);
    send_idle_pct = 17;
    stall_pct = 17;
    test_random_moves(160);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
